>>> rtl/lbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and codes of the LRU block cache controller
// Request, status and disk command codes, and the result record.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int TAG_W       = 64;

	localparam logic [2:0] REQ_GET     = 3'd0;
	localparam logic [2:0] REQ_RELEASE = 3'd1;
	localparam logic [2:0] REQ_DIRTY   = 3'd2;
	localparam logic [2:0] REQ_LOCK    = 3'd3;
	localparam logic [2:0] REQ_FLUSH   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_HERE = 2'd1;
	localparam logic [1:0] ST_NO_FREE  = 2'd2;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         result_slot;
		logic               from_disk;
		logic [1:0]         command;
		logic [3:0]         command_slot;
		logic [TAG_W-1:0]   tag;
		logic               last;
	} res_t;

	function automatic res_t mk_res(logic [1:0] st, logic [3:0] rs, logic fd,
			logic [1:0] cmd, logic [3:0] cs, logic [TAG_W-1:0] tag, logic lst);
		res_t r;
		r.status       = st;
		r.result_slot  = rs;
		r.from_disk    = fd;
		r.command      = cmd;
		r.command_slot = cs;
		r.tag          = tag;
		r.last         = lst;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/lru_block_cache_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_block_cache_controller: tag and replacement controller, LRU with pins
// Fully associative block cache control; issues disk read/write commands.
// ----------------------------------------------------------------------------
// Steps: a get walks the lookup in rank order; a miss then walks for a victim,
//   reads a dirty victim for write-back in repair mode, and fills.
// Flush in repair mode walks every entry and writes back each dirty one.
// Release, mark dirty and lock finish from idle or after one tag read. One item
//   at a time; busy is high meanwhile. The single tag RAM read port is walked in rank order.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset: all entries invalid, clean and unpinned, entry 0 most recent.
module lru_block_cache_controller #(
	parameter int ENTRIES = lbc_pkg::ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         req_type,
	input  wire logic [2:0]         req_flags,
	input  wire logic signed [15:0] volume_ref,
	input  wire logic signed [15:0] file_ref,
	input  wire logic [31:0]        block_number,
	input  wire logic [3:0]         slot,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data,
	output logic                    strobe,
	output logic [1:0]              status,
	output logic [3:0]              result_slot,
	output logic                    from_disk,
	output logic [1:0]              command,
	output logic [3:0]              command_slot,
	output logic signed [15:0]      command_volume,
	output logic signed [15:0]      command_file,
	output logic [31:0]             command_block,
	output logic                    last
);
	import lbc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// one-hot sequencer states
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_LOOK = 9'b000000010,
		S_VICT = 9'b000000100,
		S_VRD  = 9'b000001000,
		S_FILL = 9'b000010000,
		S_RRD  = 9'b000100000,
		S_FLW  = 9'b001000000,
		S_FLD  = 9'b010000000,
		S_FEND = 9'b100000000
	} state_t;

	state_t state_q;

	logic               repair_q;
	logic [ENTRIES-1:0] valid_q, pinned_q, dirty_q;

	// latched request
	logic [2:0]       flags_q;
	logic [TAG_W-1:0] tag_q;

	logic [CW-1:0]    cnt_q;      // walk cursor
	logic             cmp_v_q;    // lookup compare stage valid
	logic [IW-1:0]    cmp_pos_q;
	logic [IW-1:0]    cmp_e_q;
	logic [IW-1:0]    v_q;        // chosen entry
	logic [IW-1:0]    vpos_q;     // its rank

	// pending flush write, held until we know whether it is the last one
	logic             pend_q;
	logic [IW-1:0]    pend_e_q;
	logic [TAG_W-1:0] pend_tag_q;

	res_t             res_q;
	logic             strobe_q;

	// datapath
	logic [IW-1:0]    rd_pos, rd_entry;
	logic [IW-1:0]    walk_pos;
	logic [IW-1:0]    ram_raddr;
	logic [TAG_W-1:0] ram_rdata;
	logic             ram_we;
	logic             mru_en;
	logic [IW-1:0]    mru_pos;
	logic             hit, miss;
	logic             slot_ok;
	logic [IW-1:0]    slot_idx;
	logic [TAG_W-1:0] in_tag;

	assign in_tag   = {volume_ref, file_ref, block_number};
	assign slot_ok  = (int'(slot) < ENTRIES);
	assign slot_idx = IW'(slot);
	assign walk_pos = IW'(cnt_q - CW'(1));

	always_comb begin
		unique case (state_q)
			S_LOOK:  rd_pos = IW'(cnt_q);
			default: rd_pos = walk_pos;
		endcase
	end

	lbc_order #(.ENTRIES(ENTRIES)) u_order (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_pos   (rd_pos),
		.rd_entry (rd_entry),
		.mru_en   (mru_en),
		.mru_pos  (mru_pos)
	);

	// tag RAM read address follows the state
	always_comb begin
		unique case (state_q)
			S_IDLE:  ram_raddr = slot_idx;
			S_VICT:  ram_raddr = rd_entry;
			S_FLW:   ram_raddr = rd_entry;
			default: ram_raddr = rd_entry;
		endcase
	end

	assign ram_we = (state_q == S_FILL);

	lbc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (v_q),
		.wdata (tag_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// lookup compare of each entry, in the cycle after the cursor issues it
	assign hit  = (state_q == S_LOOK) && cmp_v_q && valid_q[cmp_e_q] &&
	              (ram_rdata == tag_q);
	assign miss = (state_q == S_LOOK) && cmp_v_q && !hit &&
	              (cmp_pos_q == IW'(ENTRIES - 1));

	always_comb begin
		mru_en  = 1'b0;
		mru_pos = vpos_q;
		if (hit) begin
			mru_en  = 1'b1;
			mru_pos = cmp_pos_q;
		end else if (state_q == S_FILL) begin
			mru_en  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			repair_q   <= 1'b0;
			valid_q    <= '0;
			pinned_q   <= '0;
			dirty_q    <= '0;
			flags_q    <= '0;
			tag_q      <= '0;
			cnt_q      <= '0;
			cmp_v_q    <= 1'b0;
			cmp_pos_q  <= '0;
			cmp_e_q    <= '0;
			v_q        <= '0;
			vpos_q     <= '0;
			pend_q     <= 1'b0;
			pend_e_q   <= '0;
			pend_tag_q <= '0;
			res_q      <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				repair_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						flags_q <= req_flags;
						tag_q   <= in_tag;
						v_q     <= slot_idx;
						// default answer: all zero, last
						res_q   <= mk_res(ST_OK, '0, 1'b0, CMD_NONE, '0, '0, 1'b1);
						unique case (req_type)
							REQ_GET: begin
								cnt_q   <= '0;
								cmp_v_q <= 1'b0;
								state_q <= S_LOOK;
							end
							REQ_RELEASE: begin
								strobe_q <= 1'b1;
								if (slot_ok) begin
									if (req_flags[0]) begin
										valid_q[slot_idx] <= 1'b0;
									end else if ((req_flags[1] || dirty_q[slot_idx]) &&
											valid_q[slot_idx]) begin
										strobe_q <= 1'b0;
										state_q  <= S_RRD;
									end
									pinned_q[slot_idx] <= 1'b0;
									dirty_q[slot_idx]  <= 1'b0;
								end
							end
							REQ_DIRTY: begin
								strobe_q <= 1'b1;
								if (slot_ok) dirty_q[slot_idx] <= 1'b1;
							end
							REQ_LOCK: begin
								strobe_q <= 1'b1;
								if (slot_ok) pinned_q[slot_idx] <= 1'b1;
							end
							REQ_FLUSH: begin
								if (repair_q) begin
									cnt_q   <= CW'(ENTRIES);
									pend_q  <= 1'b0;
									state_q <= S_FLW;
								end else begin
									strobe_q <= 1'b1;
								end
							end
							default: strobe_q <= 1'b1;
						endcase
					end
				end
				S_LOOK: begin
					if (int'(cnt_q) < ENTRIES) begin
						cmp_v_q   <= 1'b1;
						cmp_pos_q <= IW'(cnt_q);
						cmp_e_q   <= rd_entry;
						cnt_q     <= cnt_q + CW'(1);
					end else begin
						cmp_v_q <= 1'b0;
					end
					if (hit) begin
						cmp_v_q <= 1'b0;
						if (!flags_q[0]) begin
							if (!flags_q[1]) pinned_q[cmp_e_q] <= 1'b1;
							res_q <= mk_res(ST_OK, 4'(cmp_e_q), 1'b0, CMD_NONE, '0, '0, 1'b1);
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							// forced re-read of the hit entry, already most recent
							v_q     <= cmp_e_q;
							vpos_q  <= '0;
							state_q <= S_FILL;
						end
					end else if (miss) begin
						cmp_v_q <= 1'b0;
						if (flags_q[2] && !flags_q[0]) begin
							res_q <= mk_res(ST_NOT_HERE, '0, 1'b0, CMD_NONE, '0, '0, 1'b1);
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							cnt_q   <= CW'(ENTRIES);
							state_q <= S_VICT;
						end
					end
				end
				S_VICT: begin
					// least recent unpinned entry
					if (!pinned_q[rd_entry]) begin
						v_q    <= rd_entry;
						vpos_q <= walk_pos;
						dirty_q[rd_entry] <= 1'b0;
						if (repair_q && dirty_q[rd_entry] && valid_q[rd_entry]) begin
							state_q <= S_VRD;
						end else begin
							state_q <= S_FILL;
						end
					end else if (walk_pos == '0) begin
						res_q <= mk_res(ST_NO_FREE, '0, 1'b0, CMD_NONE, '0, '0, 1'b1);
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_VRD: begin
					res_q <= mk_res(ST_OK, 4'(v_q), 1'b1, CMD_WRITE, 4'(v_q), ram_rdata, 1'b0);
					strobe_q <= 1'b1;
					state_q  <= S_FILL;
				end
				S_FILL: begin
					valid_q[v_q]  <= 1'b1;
					dirty_q[v_q]  <= 1'b0;
					pinned_q[v_q] <= !flags_q[1];
					res_q <= mk_res(ST_OK, 4'(v_q), 1'b1, CMD_READ, 4'(v_q), tag_q, 1'b1);
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_RRD: begin
					res_q <= mk_res(ST_OK, '0, 1'b0, CMD_WRITE, 4'(v_q), ram_rdata, 1'b1);
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_FLW: begin
					if (valid_q[rd_entry] && dirty_q[rd_entry]) begin
						v_q     <= rd_entry;
						state_q <= S_FLD;
					end else if (walk_pos == '0) begin
						state_q <= S_FEND;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_FLD: begin
					// send the previous write; hold this one
					if (pend_q) begin
						res_q <= mk_res(ST_OK, '0, 1'b0, CMD_WRITE, 4'(pend_e_q), pend_tag_q,
						                1'b0);
						strobe_q <= 1'b1;
					end
					pend_q     <= 1'b1;
					pend_e_q   <= v_q;
					pend_tag_q <= ram_rdata;
					if (walk_pos == '0) begin
						state_q <= S_FEND;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_FLW;
					end
				end
				S_FEND: begin
					valid_q  <= '0;
					pinned_q <= '0;
					dirty_q  <= '0;
					if (pend_q) begin
						res_q <= mk_res(ST_OK, '0, 1'b0, CMD_WRITE, 4'(pend_e_q), pend_tag_q,
						                1'b1);
					end else begin
						res_q <= mk_res(ST_OK, '0, 1'b0, CMD_NONE, '0, '0, 1'b1);
					end
					pend_q   <= 1'b0;
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign cfg_ready      = !busy;
	assign strobe         = strobe_q;
	assign status         = res_q.status;
	assign result_slot    = res_q.result_slot;
	assign from_disk      = res_q.from_disk;
	assign command        = res_q.command;
	assign command_slot   = res_q.command_slot;
	assign command_volume = res_q.tag[63:48];
	assign command_file   = res_q.tag[47:32];
	assign command_block  = res_q.tag[31:0];
	assign last           = res_q.last;
endmodule
`default_nettype wire

>>> rtl/lbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/lbc_order.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_order: recency list
// ord[r] is the entry at rank r (0 = most recent); move-to-front update.
// ----------------------------------------------------------------------------
module lbc_order #(
	parameter int ENTRIES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [$clog2(ENTRIES)-1:0] rd_pos,
	output logic      [$clog2(ENTRIES)-1:0] rd_entry,
	input  wire logic                       mru_en,
	input  wire logic [$clog2(ENTRIES)-1:0] mru_pos
);
	localparam int IW = $clog2(ENTRIES);

	logic [IW-1:0] ord_q [ENTRIES];

	assign rd_entry = (int'(rd_pos) < ENTRIES) ? ord_q[rd_pos] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				ord_q[i] <= IW'(i);
			end
		end else if (mru_en) begin
			// front takes the chosen entry, ranks above it slide down one
			ord_q[0] <= ord_q[mru_pos];
			for (int i = 1; i < ENTRIES; i++) begin
				if (IW'(i) <= mru_pos) begin
					ord_q[i] <= ord_q[i-1];
				end
			end
		end
	end
endmodule
`default_nettype wire
